FILE: design/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg: shared types and constants for the half/single float converter
// Holds the word width, operation codes and the stage payload struct.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_t;

  // Decoded operand, carried from stage 1 to stage 2
  typedef struct packed {
    op_t         op;
    logic        sign;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    logic [7:0]  fexp;
    logic [22:0] fman;
    logic [3:0]  lz;      // half subnormal leading-zero count (0..9)
  } dec_t;

endpackage

FILE: design/hfc_decode.sv
// ----------------------------------------------------------------------------
// hfc_decode: stage 1 of the converter
// Splits the operand into fields and counts leading zeros of a half mantissa.
// ----------------------------------------------------------------------------
module hfc_decode
  import hfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic              in_req_type,
  input  logic [WORD_W-1:0] in_operand_bits,
  output logic              vld_r,
  output dec_t              dec_r
);

  dec_t       dec_nxt;
  logic [3:0] lz;

  // leading-zero count over ten mantissa bits
  always_comb begin
    lz = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (in_operand_bits[i]) lz = 4'(9 - i);
    end
  end

  always_comb begin
    dec_nxt.op   = op_t'(in_req_type);
    dec_nxt.sign = (in_req_type == OP_S2H) ? in_operand_bits[31] : in_operand_bits[15];
    dec_nxt.hexp = in_operand_bits[14:10];
    dec_nxt.hman = in_operand_bits[9:0];
    dec_nxt.fexp = in_operand_bits[30:23];
    dec_nxt.fman = in_operand_bits[22:0];
    dec_nxt.lz   = lz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

FILE: design/hfc_shift.sv
// ----------------------------------------------------------------------------
// hfc_shift: stage 2 of the converter
// Builds the widened single result, or the truncated half and rounding bits.
// ----------------------------------------------------------------------------
module hfc_shift
  import hfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  dec_t              dec_i,
  output logic              vld_r,
  output logic              s2h_r,    // needs rounding step
  output logic [WORD_W-1:0] base_r,   // final word (h2s) or truncated half
  output logic              rnd_r,    // round bit
  output logic              stk_r     // sticky bit
);

  logic [WORD_W-1:0] base_nxt;
  logic              rnd_nxt;
  logic              stk_nxt;
  logic [8:0]        e;         // fexp - 112, two's complement
  logic [23:0]       m;
  logic [4:0]        sh;
  logic [47:0]       wide;
  logic [9:0]        nman;

  always_comb begin
    base_nxt = '0;
    rnd_nxt  = 1'b0;
    stk_nxt  = 1'b0;
    e        = {1'b0, dec_i.fexp} - 9'd112;
    m        = {1'b1, dec_i.fman};
    sh       = 5'd0;
    wide     = '0;
    nman     = 10'(dec_i.hman << (dec_i.lz + 4'd1));
    if (dec_i.op == OP_H2S) begin
      // widen: special, normal, zero or subnormal
      if (dec_i.hexp == 5'h1F) begin
        base_nxt = {dec_i.sign, 8'hFF, dec_i.hman, 13'd0};
      end else if (dec_i.hexp != 5'd0) begin
        base_nxt = {dec_i.sign, 8'(dec_i.hexp) + 8'd112, dec_i.hman, 13'd0};
      end else if (dec_i.hman == 10'd0) begin
        base_nxt = {dec_i.sign, 31'd0};
      end else begin
        base_nxt = {dec_i.sign, 8'd113 - 8'(dec_i.lz) - 8'd1, nman, 13'd0};
      end
    end else begin
      if (dec_i.fexp == 8'hFF) begin
        base_nxt = {16'd0, dec_i.sign, 5'h1F, (dec_i.fman != 23'd0), 9'd0};
      end else if (!e[8] && e >= 9'd31) begin
        base_nxt = {16'd0, dec_i.sign, 5'h1F, 10'd0};
      end else if (e[8] || e == 9'd0) begin
        // subnormal half: shift by 14 - e
        if (e[8] && e < 9'h1F6) begin
          base_nxt = {16'd0, dec_i.sign, 15'd0};
        end else begin
          sh       = 5'(9'd14 - e);
          wide     = {m, 24'd0} >> sh;
          base_nxt = {16'd0, dec_i.sign, 15'(wide[47:24])};
          rnd_nxt  = wide[23];
          stk_nxt  = |wide[22:0];
        end
      end else begin
        base_nxt = {16'd0, dec_i.sign, e[4:0], dec_i.fman[22:13]};
        rnd_nxt  = dec_i.fman[12];
        stk_nxt  = |dec_i.fman[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2h_r  <= (dec_i.op == OP_S2H);
      base_r <= base_nxt;
      rnd_r  <= rnd_nxt;
      stk_r  <= stk_nxt;
    end
  end

endmodule

FILE: design/half_float_converter.sv
// ----------------------------------------------------------------------------
// half_float_converter: IEEE binary16 <-> binary32 conversion pipeline
// Three register stages: decode, align, round-to-nearest-even.
// ----------------------------------------------------------------------------
// One item enters per clock and its result passes the decode, align and round
// registers; the rate is one item per cycle, set by the three-stage pipeline
// that moves together whenever the output register is empty or being taken.
// in_stall follows out_stall while the output holds an untaken result.
module half_float_converter
  import hfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [WORD_W-1:0] in_operand_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_result_bits
);

  logic              adv;
  logic              v1_r;
  dec_t              dec_r;
  logic              v2_r;
  logic              s2h_r;
  logic [WORD_W-1:0] base_r;
  logic              rnd_r;
  logic              stk_r;
  logic [WORD_W-1:0] res_nxt;
  logic [WORD_W-1:0] res_r;
  logic              v3_r;

  // whole pipe moves when the output slot frees up
  assign adv      = !v3_r || !out_stall;
  assign in_stall = !adv;

  hfc_decode u_dec (
    .clk, .rst_n, .adv,
    .in_vld          (in_valid),
    .in_req_type,
    .in_operand_bits,
    .vld_r           (v1_r),
    .dec_r
  );

  hfc_shift u_shf (
    .clk, .rst_n, .adv,
    .vld_i  (v1_r),
    .dec_i  (dec_r),
    .vld_r  (v2_r),
    .s2h_r,
    .base_r,
    .rnd_r,
    .stk_r
  );

  // round to nearest even; carry runs into the exponent
  always_comb begin
    res_nxt = base_r;
    if (s2h_r && rnd_r && (stk_r || base_r[0])) begin
      res_nxt = {16'd0, base_r[15:0] + 16'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = v3_r;
  assign out_result_bits = res_r;

endmodule
